// ===== hw/rtl/swmm_pkg.sv =====
// shared types, widths and helpers of the sliding window min/max core
// no dependencies; imported by every module of the block
package swmm_pkg;

    localparam int WINDOW_MAX = 1024;
    localparam int SAMPLE_W   = 32;
    localparam int WIN_W      = 11;
    localparam int EW_W       = $clog2(WINDOW_MAX + 1);
    localparam int POS_W      = $clog2(2 * WINDOW_MAX);
    localparam int CMP_W      = (WIN_W > EW_W) ? WIN_W : EW_W;

    typedef struct packed {
        logic                       valid;
        logic signed [SAMPLE_W-1:0] value;
        logic [POS_W-1:0]           pos;
    } entry_t;

    typedef struct packed {
        logic shift;
        logic push;
    } deq_ctrl_t;

    typedef enum logic {
        ST_RUN,
        ST_PURGE
    } state_t;

    // zero acts as one, anything beyond the cell count saturates
    function automatic logic [EW_W-1:0] eff_window(input logic [WIN_W-1:0] w);
        logic [CMP_W-1:0] wx;
        wx = CMP_W'(w);
        if (wx == '0)
            return EW_W'(1);
        if (wx > CMP_W'(WINDOW_MAX))
            return EW_W'(WINDOW_MAX);
        return EW_W'(wx);
    endfunction

endpackage

// ===== hw/rtl/swmm_in_if.sv =====
// sample channel of the sliding window min/max core
// depends on swmm_pkg for the sample width
interface swmm_in_if;
    import swmm_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);

endinterface

// ===== hw/rtl/swmm_out_if.sv =====
// result channel of the sliding window min/max core
// depends on swmm_pkg for the sample width
interface swmm_out_if;
    import swmm_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] window_min;
    logic signed [SAMPLE_W-1:0] window_max;

    modport source (output valid, output window_min, output window_max, input ready);
    modport sink (input valid, input window_min, input window_max, output ready);

endinterface

// ===== hw/rtl/swmm_cell.sv =====
// one deque slot: holds a value/position pair and a valid bit
// depends on swmm_pkg; chained by swmm_deque
module swmm_cell
    import swmm_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       is_max,
    input  deq_ctrl_t                  ctrl,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic [POS_W-1:0]           spos,
    input  entry_t                     right,
    input  logic                       left_keep,
    output entry_t                     entry,
    output logic                       keep
);

    entry_t cur_reg;
    entry_t cur_next;
    entry_t view;
    logic   beaten;

    always_comb
    begin
        // head pop moves every slot one place toward the head
        view   = ctrl.shift ? right : cur_reg;
        beaten = is_max ? (view.value <= sample) : (view.value >= sample);
        keep   = view.valid && !beaten;
        cur_next = view;
        if (ctrl.push && !keep)
        begin
            // first slot past the surviving prefix takes the new sample
            if (left_keep)
            begin
                cur_next.valid = 1'b1;
                cur_next.value = sample;
                cur_next.pos   = spos;
            end
            else
            begin
                cur_next.valid = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cur_reg <= '0;
        else
            cur_reg <= cur_next;
    end

    assign entry = cur_reg;

endmodule

// ===== hw/rtl/swmm_deque.sv =====
// monotonic deque as a row of swmm_cell slots, head in slot zero
// depends on swmm_pkg and swmm_cell
module swmm_deque
    import swmm_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       is_max,
    input  deq_ctrl_t                  ctrl,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic [POS_W-1:0]           spos,
    output entry_t                     head,
    output logic signed [SAMPLE_W-1:0] head_value
);

    entry_t slot_e [WINDOW_MAX];
    logic   slot_k [WINDOW_MAX];
    entry_t head_view;

    genvar i;
    generate
        for (i = 0; i < WINDOW_MAX; i++)
        begin : g_cell
            entry_t right_e;
            logic   left_k;

            if (i == WINDOW_MAX - 1)
            begin : g_last
                assign right_e = '0;
            end
            else
            begin : g_mid
                assign right_e = slot_e[i+1];
            end

            if (i == 0)
            begin : g_first
                assign left_k = 1'b1;
            end
            else
            begin : g_rest
                assign left_k = slot_k[i-1];
            end

            swmm_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .is_max    (is_max),
                .ctrl      (ctrl),
                .sample    (sample),
                .spos      (spos),
                .right     (right_e),
                .left_keep (left_k),
                .entry     (slot_e[i]),
                .keep      (slot_k[i])
            );
        end
    endgenerate

    assign head      = slot_e[0];
    assign head_view = ctrl.shift ? slot_e[1] : slot_e[0];
    // head after this cycle's update
    assign head_value = slot_k[0] ? head_view.value : sample;

endmodule

// ===== hw/rtl/sliding_window_min_max_core.sv =====
// top level of the sliding window min/max core: control, window register, output register
// depends on swmm_pkg, swmm_in_if, swmm_out_if and swmm_deque
//
//  channel   dir  handshake     payload
//  samples   in   valid/ready   sample
//  results   out  valid/ready   window_min, window_max
//  cfg       in   cfg_we        cfg_data (window_size)
//
// one sample per clock while results are taken, cfg_we is low and no purge runs
// each deque updates all slots at once; the result is registered at its sample transfer
// reset empties both deques at once, window_size is 1
// after a window_size write, the ST_PURGE state drops stale head entries
// with samples.ready low; a stalled result stalls the sample side behind it
module sliding_window_min_max_core
    import swmm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    swmm_in_if.sink           samples,
    swmm_out_if.source        results,
    input  logic              cfg_we,
    input  logic [WIN_W-1:0]  cfg_data
);

    state_t                     state_reg, state_next;
    logic [EW_W-1:0]            win_reg, win_next;
    logic [EW_W-1:0]            seen_reg, seen_next;
    logic [EW_W-1:0]            seen_inc;
    logic [EW_W-1:0]            cfg_win;
    logic [POS_W-1:0]           pos_reg, pos_next;
    logic                       out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0] min_reg, max_reg;
    logic                       accept, in_ready, hit;
    logic                       step_shift;
    logic [POS_W-1:0]           min_age, max_age;
    logic                       min_exp, max_exp;
    entry_t                     min_head, max_head;
    logic signed [SAMPLE_W-1:0] min_hv, max_hv;
    deq_ctrl_t                  min_ctrl, max_ctrl;

    assign cfg_win = eff_window(cfg_data);
    assign accept  = samples.valid && in_ready;

    // age of each head against the position the next sample will carry
    assign min_age = pos_reg - min_head.pos;
    assign max_age = pos_reg - max_head.pos;
    assign min_exp = min_head.valid && (min_age >= POS_W'(win_reg));
    assign max_exp = max_head.valid && (max_age >= POS_W'(win_reg));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_RUN:
            begin
                if (cfg_we)
                    state_next = ST_PURGE;
            end
            ST_PURGE:
            begin
                if (!cfg_we && !min_exp && !max_exp)
                    state_next = ST_RUN;
            end
            default:
            begin
                state_next = ST_PURGE;
            end
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        step_shift = 1'b0;
        case (state_reg)
            ST_RUN:
            begin
                in_ready   = !cfg_we && (!out_valid_reg || results.ready);
                step_shift = samples.valid && in_ready;
            end
            ST_PURGE:
            begin
                step_shift = !cfg_we;
            end
            default:
            begin
                in_ready   = 1'b0;
                step_shift = 1'b0;
            end
        endcase
        min_ctrl.shift = step_shift && min_exp;
        max_ctrl.shift = step_shift && max_exp;
        min_ctrl.push  = accept;
        max_ctrl.push  = accept;
    end

    assign samples.ready = in_ready;

    always_comb
    begin
        seen_inc = (seen_reg < win_reg) ? (seen_reg + EW_W'(1)) : win_reg;
        hit      = (seen_inc == win_reg);
        win_next = win_reg;
        seen_next = seen_reg;
        pos_next = pos_reg;
        if (cfg_we)
        begin
            win_next  = cfg_win;
            seen_next = (seen_reg > cfg_win) ? cfg_win : seen_reg;
        end
        else if (accept)
        begin
            seen_next = seen_inc;
            pos_next  = pos_reg + POS_W'(1);
        end
        out_valid_next = out_valid_reg;
        if (accept)
            out_valid_next = hit;
        else if (results.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            win_reg       <= EW_W'(1);
            seen_reg      <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            win_reg       <= win_next;
            seen_reg      <= seen_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            min_reg <= min_hv;
            max_reg <= max_hv;
        end
    end

    swmm_deque u_min_deque (
        .clk        (clk),
        .rst_n      (rst_n),
        .is_max     (1'b0),
        .ctrl       (min_ctrl),
        .sample     (samples.sample),
        .spos       (pos_reg),
        .head       (min_head),
        .head_value (min_hv)
    );

    swmm_deque u_max_deque (
        .clk        (clk),
        .rst_n      (rst_n),
        .is_max     (1'b1),
        .ctrl       (max_ctrl),
        .sample     (samples.sample),
        .spos       (pos_reg),
        .head       (max_head),
        .head_value (max_hv)
    );

    assign results.valid      = out_valid_reg;
    assign results.window_min = min_reg;
    assign results.window_max = max_reg;

    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (min_reg <= max_reg))
        else $error("window minimum above window maximum");

    a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg <= win_reg)
        else $error("sample count beyond window size");

    a_result_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (out_valid_reg == (seen_reg == win_reg)))
        else $error("result presence does not match window fill");

    a_heads_after_push: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (min_head.valid && max_head.valid))
        else $error("deque head empty after a sample transfer");

endmodule

// ===== tb/tb_sliding_window_min_max_core.sv =====
`timescale 1ns / 1ps
// self-checking testbench of sliding_window_min_max_core: drives samples, window writes, stalls
// depends on swmm_pkg, swmm_in_if, swmm_out_if and the core with its submodules
module tb_sliding_window_min_max_core;
    import swmm_pkg::*;

    localparam int WATCHDOG_LIMIT = 8000;
    localparam int DRAIN_CYCLES   = 4;
    localparam int REPORT_MAX     = 10;
    localparam int RANDOM_ITEMS   = 100;

    typedef enum int {
        PAT_UNIFORM,
        PAT_NARROW,
        PAT_RISING,
        PAT_FALLING,
        PAT_EXTREMES
    } pattern_t;

    // one deque candidate: sample value and its wrapping position
    typedef struct {
        logic signed [SAMPLE_W-1:0] value;
        logic [POS_W-1:0]           pos;
    } pos_sample_t;

    typedef struct {
        logic signed [SAMPLE_W-1:0] lo;
        logic signed [SAMPLE_W-1:0] hi;
    } window_extremes_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [WIN_W-1:0] cfg_data;
    logic             quiet;

    swmm_in_if  samples_if ();
    swmm_out_if results_if ();

    sliding_window_min_max_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .samples  (samples_if),
        .results  (results_if),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    // predictor state
    pos_sample_t      min_cand[$];
    pos_sample_t      max_cand[$];
    logic [WIN_W-1:0] win_setting;
    logic [POS_W-1:0] cur_pos;
    int               seen_count;
    window_extremes_t expected_extremes[$];

    window_extremes_t checker_want;
    int               error_count;
    int               samples_sent;
    int               results_checked;
    int               window_writes;
    int               idle_cycles;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic int eff_len(input logic [WIN_W-1:0] w);
        if (w == '0)
            return 1;
        if (int'(w) > WINDOW_MAX)
            return WINDOW_MAX;
        return int'(w);
    endfunction

    function automatic logic [POS_W-1:0] age_of(input logic [POS_W-1:0] p);
        logic [POS_W-1:0] a;
        a = cur_pos - p;
        return a;
    endfunction

    // mostly the minimum length, sometimes a short gap, rarely a long one
    function automatic int gap_len(input int min_len);
        int r;
        r = $urandom_range(0, 99);
        if (quiet)
            return min_len;
        if (r < 65)
            return min_len;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] draw_sample(input pattern_t pat, input int idx,
            input logic signed [SAMPLE_W-1:0] base, input logic signed [SAMPLE_W-1:0] step);
        int r;
        int narrow;
        r = $urandom_range(0, 99);
        narrow = $urandom_range(0, 6);
        if (r < 10)
            return $urandom;
        case (pat)
            PAT_UNIFORM: return $urandom;
            PAT_NARROW:  return narrow - 3;
            PAT_RISING:  return base + idx * step;
            PAT_FALLING: return base - idx * step;
            default:
            begin
                case ($urandom_range(0, 3))
                    0: return {1'b1, {(SAMPLE_W-1){1'b0}}};
                    1: return {1'b0, {(SAMPLE_W-1){1'b1}}};
                    2: return '0;
                    default: return '1;
                endcase
            end
        endcase
    endfunction

    function automatic logic [WIN_W-1:0] pick_window();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return WIN_W'($urandom_range(1, 16));
        if (r < 90)
            return WIN_W'($urandom_range(17, 128));
        return WIN_W'($urandom_range(129, 400));
    endfunction

    // deque update for one accepted sample; queues the result once the window is full
    task automatic advance_window(input logic signed [SAMPLE_W-1:0] s);
        int               win;
        pos_sample_t      ent;
        window_extremes_t res;
        win = eff_len(win_setting);
        while (min_cand.size() > 0 && int'(age_of(min_cand[0].pos)) >= win)
            void'(min_cand.pop_front());
        while (max_cand.size() > 0 && int'(age_of(max_cand[0].pos)) >= win)
            void'(max_cand.pop_front());
        while (min_cand.size() > 0 && min_cand[$].value >= s)
            void'(min_cand.pop_back());
        while (max_cand.size() > 0 && max_cand[$].value <= s)
            void'(max_cand.pop_back());
        ent.value = s;
        ent.pos   = cur_pos;
        min_cand.push_back(ent);
        max_cand.push_back(ent);
        cur_pos = cur_pos + 1'b1;
        if (seen_count < win)
            seen_count++;
        if (seen_count > win)
            seen_count = win;
        if (seen_count >= win)
        begin
            res.lo = min_cand[0].value;
            res.hi = max_cand[0].value;
            expected_extremes.push_back(res);
        end
    endtask

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
        int gap;
        gap = gap_len(0);
        @(negedge clk);
        if (gap > 0)
        begin
            samples_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        samples_if.valid  <= 1'b1;
        samples_if.sample <= s;
        @(posedge clk);
        while (!samples_if.ready)
            @(posedge clk);
        advance_window(s);
        samples_sent++;
    endtask

    // sample side held idle and all results taken before the register changes
    task automatic drain();
        @(negedge clk);
        samples_if.valid <= 1'b0;
        while (expected_extremes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_window(input logic [WIN_W-1:0] w);
        drain();
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= w;
        @(negedge clk);
        cfg_we   <= 1'b0;
        win_setting = w;
        if (seen_count > eff_len(w))
            seen_count = eff_len(w);
        window_writes++;
    endtask

    task automatic send_pattern(input pattern_t pat, input int count);
        logic signed [SAMPLE_W-1:0] base;
        logic signed [SAMPLE_W-1:0] step;
        base = $urandom;
        step = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 9);
        for (int i = 0; i < count; i++)
            send_sample(draw_sample(pat, i, base, step));
    endtask

    task automatic test_reset_window();
        quiet = 1'b1;
        send_sample({1'b1, {(SAMPLE_W-1){1'b0}}});
        send_sample({1'b0, {(SAMPLE_W-1){1'b1}}});
        send_sample('0);
        send_sample('1);
        send_sample(32'sh5555_5555);
        send_sample(32'shAAAA_AAAA);
        send_sample(1);
    endtask

    task automatic test_ties_and_slopes();
        quiet = 1'b0;
        write_window(WIN_W'(3));
        send_sample(5);
        send_sample(5);
        send_sample(5);
        for (int i = 1; i <= 4; i++)
            send_sample(i);
        for (int i = 4; i >= 1; i--)
            send_sample(i);
        send_sample({1'b1, {(SAMPLE_W-1){1'b0}}});
        send_sample({1'b0, {(SAMPLE_W-1){1'b1}}});
        send_sample({1'b0, {(SAMPLE_W-1){1'b1}}});
        send_sample({1'b1, {(SAMPLE_W-1){1'b0}}});
    endtask

    task automatic test_window_zero();
        write_window('0);
        send_sample(-7);
        send_sample(9);
        send_sample(-7);
    endtask

    // state kept across size changes: shrink drops stale heads, grow holds results back
    task automatic test_resize_midstream();
        write_window(WIN_W'(16));
        send_pattern(PAT_UNIFORM, 20);
        write_window(WIN_W'(4));
        send_pattern(PAT_NARROW, 10);
        write_window(WIN_W'(12));
        send_pattern(PAT_FALLING, 15);
        write_window(WIN_W'(2));
        write_window(WIN_W'(9));
        send_pattern(PAT_EXTREMES, 14);
    endtask

    task automatic test_full_window();
        quiet = 1'b0;
        write_window(WIN_W'(WINDOW_MAX));
        send_pattern(PAT_UNIFORM, WINDOW_MAX + 8);
        // a setting beyond the deque depth acts as the full depth
        write_window('1);
        send_pattern(PAT_NARROW, 20);
        write_window(WIN_W'(WINDOW_MAX + 1));
        send_pattern(PAT_RISING, 10);
    endtask

    task automatic test_random_stream();
        int       done;
        int       len;
        pattern_t pat;
        done = 0;
        while (done < RANDOM_ITEMS)
        begin
            quiet = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) != 0)
                write_window(pick_window());
            len = $urandom_range(20, 80);
            pat = pattern_t'($urandom_range(0, 4));
            send_pattern(pat, len);
            done += len;
        end
    endtask

    // result side stalls
    initial
    begin
        results_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 4) == 0)
            begin
                results_if.ready <= 1'b0;
                repeat (gap_len(1)) @(negedge clk);
            end
            results_if.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && results_if.valid && results_if.ready)
        begin
            results_checked++;
            if (expected_extremes.size() == 0)
            begin
                error_count++;
                if (error_count <= REPORT_MAX)
                    $display("%0t: unexpected result min %0d max %0d", $realtime,
                        results_if.window_min, results_if.window_max);
            end
            else
            begin
                checker_want = expected_extremes.pop_front();
                if (results_if.window_min !== checker_want.lo)
                begin
                    error_count++;
                    if (error_count <= REPORT_MAX)
                        $display("%0t: window_min expected %0d got %0d", $realtime,
                            checker_want.lo, results_if.window_min);
                end
                if (results_if.window_max !== checker_want.hi)
                begin
                    error_count++;
                    if (error_count <= REPORT_MAX)
                        $display("%0t: window_max expected %0d got %0d", $realtime,
                            checker_want.hi, results_if.window_max);
                end
            end
        end
    end

    // no transfer on either channel for too long means a hang
    initial
    begin
        idle_cycles = 0;
        @(posedge rst_n);
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((samples_if.valid && samples_if.ready) || (results_if.valid && results_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
            WATCHDOG_LIMIT, expected_extremes.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_data          = '0;
        samples_if.valid  = 1'b0;
        samples_if.sample = '0;
        quiet             = 1'b1;
        win_setting       = WIN_W'(1);
        cur_pos           = '0;
        seen_count        = 0;
        error_count       = 0;
        samples_sent      = 0;
        results_checked   = 0;
        window_writes     = 0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        test_reset_window();
        test_ties_and_slopes();
        test_window_zero();
        test_resize_midstream();
        test_full_window();
        test_random_stream();

        drain();
        repeat (10) @(posedge clk);
        if (expected_extremes.size() != 0)
        begin
            error_count += expected_extremes.size();
            $display("%0d expected results never arrived", expected_extremes.size());
        end
        $display("sent %0d samples, checked %0d results over %0d window writes",
            samples_sent, results_checked, window_writes);
        $display("windows 0, 1, small, resized both ways, full depth and beyond; %0d errors",
            error_count);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
